### rtl/fcv_pkg.sv
// Shared constants, types and register indexes for the 1-D FIR convolution block.
`timescale 1ns / 1ps

package fcv_pkg;

   localparam int MAX_TAPS    = 7;
   localparam int SAMPLE_BITS = 16;
   localparam int WEIGHT_BITS = 18;
   localparam int FRAC_BITS   = 16;
   localparam int RES_BITS    = 24;
   localparam int HW_BITS     = 2;
   localparam int COUNT_BITS  = 3;
   localparam int CSR_IDX_BITS = 3;

   localparam int PROD_BITS = SAMPLE_BITS + WEIGHT_BITS;
   localparam int ACC_BITS  = PROD_BITS + $clog2(MAX_TAPS);
   // rounding add needs one guard bit; keep room for the saturation limits too
   localparam int RND_BITS  = (ACC_BITS + 1 > RES_BITS + 1) ? ACC_BITS + 1 : RES_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // register map
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WEIGHT_BASE = 3'd1;

   localparam logic [HW_BITS-1:0]            HALF_WIDTH_RESET = 2'd3;
   localparam int                            CENTER_TAP       = 3;
   localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_UNITY     = 18'sh10000;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [WEIGHT_BITS-1:0] weight_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;

   typedef weight_type weight_array_type [MAX_TAPS];
   typedef sample_type sample_array_type [MAX_TAPS];
   typedef prod_type   prod_array_type   [MAX_TAPS];

   // per-item control handed from the multiply stage to the output stage
   typedef struct packed {
      logic       emit_main;   // item emits its own result word
      logic       main_zero;   // that word is a border zero
      logic [1:0] extra;       // zero words drained after it
      logic       last;        // item closes the run
   } ctrl_type;

endpackage

### rtl/fcv_front.sv
// Sample window, run counter and the registered tap products.
`timescale 1ns / 1ps

module fcv_front import fcv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  sample_type             req_sample,
   input  logic                   req_final,
   input  logic [HW_BITS-1:0]     half_width,
   input  weight_array_type       weights,
   output logic                   p_valid,
   output ctrl_type               p_ctrl,
   output prod_array_type         p_prod,
   input  logic                   p_take
);

   sample_array_type win_ff, win_in, win_sh;
   logic [COUNT_BITS-1:0] seen_ff, seen_in;
   logic                  p_valid_ff, p_valid_in;
   ctrl_type              ctrl_ff, ctrl_in;
   prod_array_type        prod_ff, prod_in;
   logic                  accept;
   logic [COUNT_BITS-1:0] h_ext, tap_lim;

   assign req_tready = !p_valid_ff || p_take;
   assign accept     = req_tvalid && req_tready;
   assign h_ext      = COUNT_BITS'(half_width);
   assign tap_lim    = {half_width, 1'b0};

   always_comb begin
      win_sh[0] = req_sample;
      for (int i = 1; i < MAX_TAPS; i++) begin
         win_sh[i] = win_ff[i-1];
      end
      // signed product, taps past 2h contribute nothing
      for (int m = 0; m < MAX_TAPS; m++) begin
         prod_in[m] = '0;
         if (m <= int'(tap_lim)) begin
            prod_in[m] = win_sh[m] * weights[m];
         end
      end

      ctrl_in.emit_main = seen_ff >= h_ext;
      ctrl_in.main_zero = seen_ff < tap_lim;
      ctrl_in.last      = req_final;
      if (!req_final) begin
         ctrl_in.extra = 2'd0;
      end else if (seen_ff >= h_ext) begin
         ctrl_in.extra = half_width;
      end else begin
         // count is below h here, so count + 1 fits
         ctrl_in.extra = seen_ff[1:0] + 2'd1;
      end

      win_in     = win_ff;
      seen_in    = seen_ff;
      p_valid_in = p_valid_ff;
      if (accept) begin
         p_valid_in = 1'b1;
         if (req_final) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
               win_in[i] = '0;
            end
            seen_in = '0;
         end else begin
            win_in = win_sh;
            if (seen_ff != COUNT_MAX) begin
               seen_in = seen_ff + 1'b1;
            end
         end
      end else if (p_take) begin
         p_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            win_ff[i] <= '0;
         end
         seen_ff    <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         win_ff     <= win_in;
         seen_ff    <= seen_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff <= ctrl_in;
         prod_ff <= prod_in;
      end
   end

   assign p_valid = p_valid_ff;
   assign p_ctrl  = ctrl_ff;
   assign p_prod  = prod_ff;

endmodule

### rtl/fcv_drain.sv
// Tap sum with rounding and saturation, output register and end-of-run zero drain.
`timescale 1ns / 1ps

module fcv_drain import fcv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       p_valid,
   input  ctrl_type                   p_ctrl,
   input  prod_array_type             p_prod,
   output logic                       p_take,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic signed [RES_BITS-1:0] rsp_result,
   output logic                       rsp_end
);

   localparam logic signed [RND_BITS-1:0] RES_HI = RND_BITS'((64'sd1 <<< (RES_BITS-1)) - 1);
   localparam logic signed [RND_BITS-1:0] RES_LO = -RND_BITS'(64'sd1 <<< (RES_BITS-1));
   localparam logic signed [RND_BITS-1:0] HALF_LSB = RND_BITS'(64'sd1 <<< (FRAC_BITS-1));

   logic                       valid_ff, valid_in;
   logic signed [RES_BITS-1:0] data_ff, data_in;
   logic                       end_ff, end_in;
   logic [1:0]                 rem_ff, rem_in;
   logic                       tail_ff, tail_in;

   logic signed [RND_BITS-1:0] acc, rnd, quo;
   logic signed [RES_BITS-1:0] sat;
   logic                       has_words, out_free, load;
   logic [1:0]                 rem_load;

   always_comb begin
      acc = '0;
      for (int m = 0; m < MAX_TAPS; m++) begin
         acc = acc + RND_BITS'(p_prod[m]);
      end
      rnd = acc + HALF_LSB;
      quo = rnd >>> FRAC_BITS;       // floor after the half-LSB bias
      if (quo > RES_HI) begin
         sat = RES_HI[RES_BITS-1:0];
      end else if (quo < RES_LO) begin
         sat = RES_LO[RES_BITS-1:0];
      end else begin
         sat = quo[RES_BITS-1:0];
      end
   end

   assign has_words = p_ctrl.emit_main || (p_ctrl.extra != 2'd0);
   assign out_free  = !valid_ff || (rsp_tready && rem_ff == 2'd0);
   assign load      = p_valid && has_words && out_free;
   assign p_take    = p_valid && (!has_words || out_free);
   assign rem_load  = p_ctrl.emit_main ? p_ctrl.extra : p_ctrl.extra - 2'd1;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      end_in   = end_ff;
      rem_in   = rem_ff;
      tail_in  = tail_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = (p_ctrl.emit_main && !p_ctrl.main_zero) ? sat : '0;
         rem_in   = rem_load;
         tail_in  = p_ctrl.last;
         end_in   = p_ctrl.last && (rem_load == 2'd0);
      end else if (valid_ff && rsp_tready) begin
         if (rem_ff != 2'd0) begin
            data_in = '0;
            rem_in  = rem_ff - 2'd1;
            end_in  = tail_ff && (rem_ff == 2'd1);
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rem_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      end_ff  <= end_in;
      tail_ff <= tail_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = data_ff;
   assign rsp_end    = end_ff;

endmodule

### rtl/fir_convolution_1d.sv
// Top level of the streaming 1-D FIR convolution with same-size output.
`timescale 1ns / 1ps

// Streaming convolution of a finite run of signed 16-bit samples with a
// centered kernel of 2h+1 signed Q1.16 taps (h = half_width, 0..3). One
// result word per sample position; the first h and last h words of a run
// are zero. Sample k (k >= h) produces word k-h, and the sample marked with
// req_tlast also drains the pending border zeros, with rsp_tlast on the
// final word. Results are rounded (ties up) from Q.16 and saturated to 24
// bits. Throughput is one sample per cycle while the output is not stalled:
// all taps multiply in parallel into a product register, which is summed,
// rounded and saturated into the output register before rsp_tvalid rises.
// A final sample yields up to h+1 words, handed out by the output register
// one word per cycle while rsp_tready is high; the product stage keeps the
// input open during that time for one more sample. Configuration must be
// written only while idle (the block does not enforce this): csr_index 0
// is half_width, 1..7 are weight_0 to weight_6.
module fir_convolution_1d import fcv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,   // [15:0] sample
   input  logic                    req_tlast,   // is_final
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [23:0]             rsp_tdata,   // [23:0] result
   output logic                    rsp_tlast,   // end_of_run
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WEIGHT_BITS-1:0]  csr_wdata
);

   logic [HW_BITS-1:0] hw_ff;
   weight_array_type   weight_ff;

   logic                       p_valid, p_take;
   ctrl_type                   p_ctrl;
   prod_array_type             p_prod;
   logic signed [RES_BITS-1:0] result;
   logic [CSR_IDX_BITS-1:0]    widx;

   assign widx = csr_index - CSR_WEIGHT_BASE;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= HALF_WIDTH_RESET;
         for (int i = 0; i < MAX_TAPS; i++) begin
            weight_ff[i] <= (i == CENTER_TAP) ? WEIGHT_UNITY : '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_HALF_WIDTH) begin
            hw_ff <= csr_wdata[HW_BITS-1:0];
         end else begin
            weight_ff[widx] <= csr_wdata;
         end
      end
   end

   fcv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_tdata),
      .req_final  (req_tlast),
      .half_width (hw_ff),
      .weights    (weight_ff),
      .p_valid    (p_valid),
      .p_ctrl     (p_ctrl),
      .p_prod     (p_prod),
      .p_take     (p_take)
   );

   fcv_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .p_valid    (p_valid),
      .p_ctrl     (p_ctrl),
      .p_prod     (p_prod),
      .p_take     (p_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result),
      .rsp_end    (rsp_tlast)
   );

   assign rsp_tdata = result;

   // product stage holds while the output is busy
   a_prod_hold: assert property (@(posedge clock) disable iff (reset)
      p_valid && !p_take |=> p_valid && $stable(p_ctrl))
      else $error("product stage changed while stalled");

   // an item that owes words lands in the output register
   a_word_loaded: assert property (@(posedge clock) disable iff (reset)
      p_valid && p_take && (p_ctrl.emit_main || p_ctrl.extra != 2'd0) |=> rsp_tvalid)
      else $error("pending word lost between stages");

   // zero drain only happens on the run's final sample
   a_drain_on_last: assert property (@(posedge clock) disable iff (reset)
      p_valid && p_ctrl.extra != 2'd0 |-> p_ctrl.last)
      else $error("drain words on a non-final sample");

endmodule

### tb/tb_fir_convolution_1d.sv
// Self-checking testbench for the streaming 1-D FIR convolution block.
`timescale 1ns / 1ps

// Drives runs of signed samples into fir_convolution_1d and checks every
// result word against an in-bench convolution model.
// - Directed table first: reset kernel (delay by h), short runs, a one-sample
//   run, h = 0 with the most negative weight, ties in the rounding, and a full
//   7-tap kernel at maximum weight. Values that are obvious are typed into the
//   table; everything else comes from the model.
// - Random phases next: each reprograms h and all seven weights while idle,
//   then sends mostly well-formed runs (long enough for a full window) plus
//   some short runs of at most 2h+1 samples, mostly border zeros.
// - Sender works in bursts with gaps; receiver stalls on its own pattern.
module tb_fir_convolution_1d;
   import fcv_pkg::*;

   localparam int RANDOM_ITEMS  = 360;
   localparam int PHASE_ITEMS   = 48;
   localparam int SETTLE_CYCLES = 8;     // pipeline registers plus up to h+1 drain words
   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake of any kind
   localparam int NUM_ROWS      = 35;

   localparam longint SAT_HI = (64'sd1 <<< (RES_BITS - 1)) - 1;
   localparam longint SAT_LO = -(64'sd1 <<< (RES_BITS - 1));

   typedef enum logic [1:0] {ROW_HW, ROW_WEIGHT, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   // One directed step: a register write or a sample. For samples, pin marks
   // a hand-typed value for the first word the sample produces.
   typedef struct packed {
      row_kind_type           kind;
      logic [2:0]             tap;
      logic [WEIGHT_BITS-1:0] arg;
      logic                   fin;
      logic                   pin;
      logic [RES_BITS-1:0]    typed;
   } test_row_type;

   typedef struct packed {
      logic [RES_BITS-1:0] value;
      logic                tail;
   } conv_word_type;

   localparam test_row_type ROWS [NUM_ROWS] = '{
      // reset kernel: h = 3, unity center tap -> output i is sample i
      '{ROW_SAMPLE, 3'd0, 18'h07FFF, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h00001, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b0, 1'b1, 24'h000000},  // leading border
      '{ROW_SAMPLE, 3'd0, 18'h0FFFF, 1'b0, 1'b1, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h01234, 1'b0, 1'b1, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h04321, 1'b1, 1'b1, 24'hFF8000},  // center = x3
      // run shorter than the kernel: all zeros, drained by the last word
      '{ROW_SAMPLE, 3'd0, 18'h07FFF, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b1, 1'b0, 24'h000000},
      // one-sample run
      '{ROW_SAMPLE, 3'd0, 18'h00005, 1'b1, 1'b0, 24'h000000},
      // h = 0, weight -2.0
      '{ROW_HW,     3'd0, 18'h00000, 1'b0, 1'b0, 24'h000000},
      '{ROW_WEIGHT, 3'd0, 18'h20000, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h07FFF, 1'b0, 1'b1, 24'hFF0002},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b0, 1'b1, 24'h010000},
      '{ROW_SAMPLE, 3'd0, 18'h00000, 1'b1, 1'b1, 24'h000000},
      // weight 0.5: ties round toward +inf
      '{ROW_WEIGHT, 3'd0, 18'h08000, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h00001, 1'b0, 1'b1, 24'h000001},
      '{ROW_SAMPLE, 3'd0, 18'h0FFFF, 1'b0, 1'b1, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h00003, 1'b0, 1'b1, 24'h000002},
      '{ROW_SAMPLE, 3'd0, 18'h0FFFD, 1'b1, 1'b1, 24'hFFFFFF},
      // full 7-tap kernel, every weight at its maximum
      '{ROW_HW,     3'd0, 18'h00003, 1'b0, 1'b0, 24'h000000},
      '{ROW_WEIGHT, 3'd0, 18'h1FFFF, 1'b0, 1'b0, 24'h000000},
      '{ROW_WEIGHT, 3'd1, 18'h1FFFF, 1'b0, 1'b0, 24'h000000},
      '{ROW_WEIGHT, 3'd2, 18'h1FFFF, 1'b0, 1'b0, 24'h000000},
      '{ROW_WEIGHT, 3'd3, 18'h1FFFF, 1'b0, 1'b0, 24'h000000},
      '{ROW_WEIGHT, 3'd4, 18'h1FFFF, 1'b0, 1'b0, 24'h000000},
      '{ROW_WEIGHT, 3'd5, 18'h1FFFF, 1'b0, 1'b0, 24'h000000},
      '{ROW_WEIGHT, 3'd6, 18'h1FFFF, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h08000, 1'b0, 1'b0, 24'h000000},
      '{ROW_SAMPLE, 3'd0, 18'h07FFF, 1'b1, 1'b0, 24'h000000}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [15:0]             req_tdata = '0;     // [15:0] sample
   logic                    req_tlast = 1'b0;   // is_final
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   logic [23:0]             rsp_tdata;          // [23:0] result
   logic                    rsp_tlast;          // end_of_run
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [WEIGHT_BITS-1:0]  csr_wdata = '0;

   fir_convolution_1d u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Convolution model state: window newest first, samples seen, kernel.
   sample_type             window_model [MAX_TAPS];
   logic [COUNT_BITS-1:0]  seen_model;
   logic [HW_BITS-1:0]     hw_model;
   weight_type             wt_model [MAX_TAPS];

   conv_word_type conv_words_due [$];
   conv_word_type head_word;

   int errors        = 0;
   int words_checked = 0;
   int samples_sent  = 0;
   int runs_sent     = 0;
   int kernels_used  = 0;
   int quiet_cycles  = 0;

   rx_mode_type rx_mode = RX_OPEN;
   logic [6:0]  rx_left = '0;

   task automatic reset_model();
      hw_model   = HALF_WIDTH_RESET;
      seen_model = '0;
      for (int m = 0; m < MAX_TAPS; m++) begin
         wt_model[m]     = '0;
         window_model[m] = '0;
      end
      wt_model[CENTER_TAP] = WEIGHT_UNITY;
   endtask

   task automatic set_reg(input logic [CSR_IDX_BITS-1:0] idx,
                          input logic [WEIGHT_BITS-1:0] val);
      if (idx == CSR_HALF_WIDTH) begin
         hw_model = val[HW_BITS-1:0];
      end else begin
         wt_model[int'(idx) - int'(CSR_WEIGHT_BASE)] = val;
      end
   endtask

   // Steps the model by one accepted sample and queues the words it produces.
   task automatic convolve_sample(input sample_type s, input bit fin,
                                  input bit pin, input logic [RES_BITS-1:0] pinned);
      int            k;
      int            h;
      int            taps;
      int            extra;
      longint        acc;
      longint        q;
      conv_word_type w;
      k = seen_model;
      h = hw_model;
      for (int i = MAX_TAPS - 1; i > 0; i--) window_model[i] = window_model[i-1];
      window_model[0] = s;
      if (k >= h) begin
         w = '0;
         if (k >= 2 * h) begin
            taps = (2 * h + 1 > MAX_TAPS) ? MAX_TAPS : 2 * h + 1;
            acc  = 0;
            for (int m = 0; m < taps; m++)
               acc += longint'(window_model[m]) * longint'(wt_model[m]);
            q = (acc + 64'sd32768) >>> FRAC_BITS;   // round half up
            if (q > SAT_HI) q = SAT_HI;
            if (q < SAT_LO) q = SAT_LO;
            w.value = q[RES_BITS-1:0];
         end
         if (pin) w.value = pinned;
         conv_words_due.push_back(w);
         extra = fin ? h : 0;
      end else begin
         extra = fin ? k + 1 : 0;
      end
      repeat (extra) conv_words_due.push_back('0);
      if (fin) begin
         // last word of the run carries tlast; window starts over
         w = conv_words_due.pop_back();
         w.tail = 1'b1;
         conv_words_due.push_back(w);
         for (int m = 0; m < MAX_TAPS; m++) window_model[m] = '0;
         seen_model = '0;
      end else if (seen_model != COUNT_MAX) begin
         seen_model++;
      end
   endtask

   // Holds valid until the word is taken, then updates the model.
   task automatic push_sample(input sample_type s, input bit fin,
                              input bit pin, input logic [RES_BITS-1:0] pinned);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      convolve_sample(s, fin, pin, pinned);
      samples_sent++;
      if (fin) runs_sent++;
   endtask

   // Drops valid and waits for every expected word, then a settle tail.
   // With nothing due and no tail it leaves valid alone.
   task automatic drain_results(input int tail);
      if (conv_words_due.size() != 0 || tail > 0) begin
         req_tvalid <= 1'b0;
         while (conv_words_due.size() != 0) @(posedge clock);
         repeat (tail) @(posedge clock);
      end
   endtask

   // Caller drops csr_we after the last write of a group.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [WEIGHT_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      set_reg(idx, val);
   endtask

   // Writes h and all seven weights. Style 0: all max, 1: all min, else mixed.
   task automatic program_kernel(input logic [HW_BITS-1:0] h, input int style);
      logic [WEIGHT_BITS-1:0] wv;
      drain_results(SETTLE_CYCLES);
      // upper bits of the half_width write are don't-care
      write_reg(CSR_HALF_WIDTH, {WEIGHT_BITS'($urandom) >> HW_BITS << HW_BITS} | h);
      for (int m = 0; m < MAX_TAPS; m++) begin
         case (style)
            0: wv = 18'h1FFFF;
            1: wv = 18'h20000;
            default: begin
               case ($urandom_range(0, 5))
                  0: wv = 18'h1FFFF;
                  1: wv = 18'h20000;
                  2: wv = '0;
                  default: wv = WEIGHT_BITS'($urandom);
               endcase
            end
         endcase
         write_reg(CSR_WEIGHT_BASE + CSR_IDX_BITS'(m), wv);
      end
      csr_we <= 1'b0;
      kernels_used++;
   endtask

   // Receiver: each time its countdown runs out, switches between always-ready,
   // sparse random, and a one-in-four periodic pattern.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 2));
         rx_left <= 7'($urandom_range(8, 64));
      end else begin
         rx_left <= rx_left - 1'b1;
      end
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 9) < 3);
         default:   rsp_tready <= (rx_left[1:0] == 2'd0);
      endcase
   end

   // Output checker: each word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (conv_words_due.size() == 0) begin
            $display("%0t: unexpected word: result %h tlast %b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            head_word = conv_words_due.pop_front();
            words_checked++;
            if (rsp_tdata !== head_word.value) begin
               $display("%0t: result mismatch: expected %h actual %h",
                        $time, head_word.value, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== head_word.tail) begin
               $display("%0t: tlast mismatch: expected %b actual %b",
                        $time, head_word.tail, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d words still due",
                  $time, quiet_cycles, conv_words_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit                 cfg_open;
      bit                 gaps_on;
      int                 burst_left;
      int                 random_sent;
      int                 phase;
      int                 phase_sent;
      int                 run_len;
      int                 h;
      logic [HW_BITS-1:0] next_hw;
      sample_type         s;

      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; register groups are written only once idle
      cfg_open = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         case (ROWS[r].kind)
            ROW_SAMPLE: begin
               if (cfg_open) begin
                  csr_we   <= 1'b0;
                  cfg_open = 1'b0;
               end
               push_sample(ROWS[r].arg[SAMPLE_BITS-1:0], ROWS[r].fin,
                           ROWS[r].pin, ROWS[r].typed);
            end
            default: begin
               if (!cfg_open) begin
                  drain_results(SETTLE_CYCLES);
                  cfg_open = 1'b1;
               end
               if (ROWS[r].kind == ROW_HW)
                  write_reg(CSR_HALF_WIDTH, ROWS[r].arg);
               else
                  write_reg(CSR_WEIGHT_BASE + ROWS[r].tap, ROWS[r].arg);
            end
         endcase
      end

      // random phases: new kernel each phase, extremes first
      random_sent = 0;
      phase       = 0;
      burst_left  = $urandom_range(1, 20);
      while (random_sent < RANDOM_ITEMS) begin
         next_hw = (phase < 4) ? HW_BITS'(3 - phase) : HW_BITS'($urandom_range(0, 3));
         program_kernel(next_hw, phase);
         h          = next_hw;
         gaps_on    = ($urandom_range(0, 3) != 0);
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS && random_sent < RANDOM_ITEMS) begin
            // now and then hold off until the pipe is empty
            if ($urandom_range(0, 9) == 0) drain_results(0);
            if ($urandom_range(0, 4) == 0)
               run_len = $urandom_range(1, 2 * h + 1);
            else
               run_len = $urandom_range(2 * h + 1, 14);
            for (int j = 0; j < run_len; j++) begin
               if ($urandom_range(0, 7) == 0)
                  s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               else
                  s = sample_type'($urandom);
               push_sample(s, j == run_len - 1, 1'b0, '0);
               random_sent++;
               phase_sent++;
               if (gaps_on) begin
                  burst_left--;
                  if (burst_left <= 0) begin
                     req_tvalid <= 1'b0;
                     repeat ($urandom_range(1, 6)) @(posedge clock);
                     burst_left = $urandom_range(1, 20);
                  end
               end
            end
         end
         phase++;
      end

      drain_results(SETTLE_CYCLES + 2);

      $display("Sent %0d samples in %0d runs across %0d random kernels plus the directed table;",
               samples_sent, runs_sent, kernels_used);
      $display("checked %0d result words, h from 0 to 3, weights at both limits.",
               words_checked);
      if (errors == 0 && conv_words_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
